// ===== rtl/icc_pkg.sv =====
// Shared constants, types and register codes for the clamped-edge image convolution block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_MASK   = 5;
  localparam int COEF_BITS  = 10;
  localparam int HALF       = MAX_MASK / 2;
  // line store rows; a power of two so the row slot is a plain bit-select
  localparam int NSLOT      = 8;
  localparam int SLOT_W     = $clog2(NSLOT);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = COL_W + 1;
  localparam int ROW_W      = 16;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int COEF_ROW_W = COEF_BITS * MAX_MASK;
  localparam int MSIZE_W    = 3;
  localparam int SHIFT_W    = 4;
  localparam int PROD_W     = COEF_BITS + CH_W + 1;
  localparam int RSUM_W     = PROD_W + $clog2(MAX_MASK);
  localparam int TSUM_W     = RSUM_W + $clog2(MAX_MASK);
  localparam int STEP_W     = $clog2(HALF + 1);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_ROW0,
    REG_COEF_ROW1,
    REG_COEF_ROW2,
    REG_COEF_ROW3,
    REG_COEF_ROW4,
    REG_NORM_SHIFT,
    REG_MASK_COLS,
    REG_MASK_ROWS
  } cfg_reg_t;

  typedef struct packed {
    logic [MAX_MASK-1:0][COEF_ROW_W-1:0] coef;
    logic [SHIFT_W-1:0]                  norm_shift;
    logic [MSIZE_W-1:0]                  mask_cols;
    logic [MSIZE_W-1:0]                  mask_rows;
  } cfg_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic err;
  } flags_t;

  typedef struct packed {
    logic [COL_W-1:0]                  col;
    logic [MAX_MASK-1:0][COL_W-1:0]    lim;
    logic [MAX_MASK-1:0][SLOT_W-1:0]   slot;
    flags_t                            flags;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  addr;
    logic [PIX_W-1:0]  data;
  } line_wr_t;

endpackage

`default_nettype wire

// ===== rtl/icc_front.sv =====
// Front end: takes pixel and drain requests, keeps the raster counters, writes the
// line store and issues one window job per due output. Depends on icc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire icc_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic [icc_pkg::CH_W-1:0]      in_red_in,
  input  wire logic [icc_pkg::CH_W-1:0]      in_green_in,
  input  wire logic [icc_pkg::CH_W-1:0]      in_blue_in,
  input  wire logic [icc_pkg::CH_W-1:0]      in_alpha_in,
  input  wire logic                          in_row_end_in,
  input  wire logic                          in_frame_end_in,
  input  wire logic                          q_full,
  output logic                               q_push,
  output icc_pkg::job_t                      q_job,
  output icc_pkg::line_wr_t                  line_wr
);

  logic [icc_pkg::WID_W-1:0]  lw_r, lw_a, lw_nxt;
  logic [icc_pkg::COL_W-1:0]  icol_r, icol_a, icol_nxt;
  logic [icc_pkg::ROW_W-1:0]  irow_r, irow_a, irow_nxt;
  logic                       closed_r, closed_a, closed_nxt;
  logic [icc_pkg::ROW_W-1:0]  lrow_r, lrow_a, lrow_nxt;
  logic [icc_pkg::WID_W-1:0]  lcnt_r, lcnt_a, lcnt_nxt;
  logic [icc_pkg::COL_W-1:0]  ocol_r, ocol_nxt;
  logic [icc_pkg::ROW_W-1:0]  orow_r, orow_nxt;
  logic [icc_pkg::SLOT_W-1:0] base_r, base_nxt;

  logic                       acc, pix_acc, row_done, due, is_last, row_end, err;
  logic [icc_pkg::WID_W-1:0]  colp1, cpos, ocp1, wrow, wy;
  logic [icc_pkg::ROW_W:0]    need;
  logic [icc_pkg::ROW_W-1:0]  bottom, ysel;
  logic signed [icc_pkg::ROW_W+1:0] yy;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign pix_acc  = acc && !in_command && !closed_r;

  assign line_wr.en   = pix_acc;
  assign line_wr.slot = base_r + irow_r[icc_pkg::SLOT_W-1:0];
  assign line_wr.addr = icol_r;
  assign line_wr.data = {in_alpha_in, in_blue_in, in_green_in, in_red_in};

  assign err = !cfg.mask_cols[0] || !cfg.mask_rows[0] ||
               (cfg.mask_cols > icc_pkg::MSIZE_W'(icc_pkg::MAX_MASK)) ||
               (cfg.mask_rows > icc_pkg::MSIZE_W'(icc_pkg::MAX_MASK));

  // counters after this request's pixel is taken in
  always_comb begin
    lw_a     = lw_r;
    icol_a   = icol_r;
    irow_a   = irow_r;
    closed_a = closed_r;
    lrow_a   = lrow_r;
    lcnt_a   = lcnt_r;
    colp1    = {1'b0, icol_r} + icc_pkg::WID_W'(1);
    row_done = 1'b0;
    if (pix_acc) begin
      if (lw_r == '0) begin
        row_done = in_row_end_in || in_frame_end_in ||
                   (icol_r == icc_pkg::COL_W'(icc_pkg::MAX_WIDTH - 1));
        if (row_done) begin
          lw_a = colp1;
        end
      end else begin
        row_done = (colp1 >= lw_r) || in_frame_end_in;
      end
      if (in_frame_end_in) begin
        closed_a = 1'b1;
        lrow_a   = irow_r;
        lcnt_a   = colp1;
      end else if (row_done) begin
        icol_a = '0;
        irow_a = irow_r + icc_pkg::ROW_W'(1);
      end else begin
        icol_a = icol_r + icc_pkg::COL_W'(1);
      end
    end
  end

  always_comb begin
    need = {1'b0, orow_r} + (icc_pkg::ROW_W+1)'(icc_pkg::HALF);
    cpos = {1'b0, ocol_r} + icc_pkg::WID_W'(icc_pkg::HALF);
    if (cpos > lw_a - icc_pkg::WID_W'(1)) begin
      cpos = lw_a - icc_pkg::WID_W'(1);
    end
    if (closed_a) begin
      due = 1'b1;
    end else if (lw_a == '0) begin
      due = 1'b0;
    end else if ({1'b0, irow_a} > need) begin
      due = 1'b1;
    end else if ({1'b0, irow_a} < need) begin
      due = 1'b0;
    end else begin
      due = {1'b0, icol_a} > cpos;
    end
  end

  // window rows, clamped top and bottom; each row clamps its columns to its own width
  always_comb begin
    bottom = closed_a ? lrow_a : irow_a;
    yy     = '0;
    ysel   = '0;
    wy     = '0;
    q_job.col   = ocol_r;
    q_job.lim   = '0;
    q_job.slot  = '0;
    q_job.flags.row_end   = row_end;
    q_job.flags.frame_end = is_last;
    q_job.flags.err       = err;
    for (int r = 0; r < icc_pkg::MAX_MASK; r++) begin
      yy = $signed({2'b00, orow_r}) + (icc_pkg::ROW_W+2)'(r - icc_pkg::HALF);
      if (yy < 0) begin
        yy = '0;
      end
      if (yy > $signed({2'b00, bottom})) begin
        yy = $signed({2'b00, bottom});
      end
      ysel = yy[icc_pkg::ROW_W-1:0];
      wy   = (closed_a && (ysel == lrow_a)) ? lcnt_a : lw_a;
      if (wy == '0) begin
        wy = icc_pkg::WID_W'(1);
      end
      q_job.lim[r]  = icc_pkg::COL_W'(wy - icc_pkg::WID_W'(1));
      q_job.slot[r] = base_r + ysel[icc_pkg::SLOT_W-1:0];
    end
  end

  always_comb begin
    wrow = (closed_a && (orow_r == lrow_a)) ? lcnt_a : lw_a;
    if (wrow == '0) begin
      wrow = icc_pkg::WID_W'(1);
    end
    ocp1    = {1'b0, ocol_r} + icc_pkg::WID_W'(1);
    is_last = closed_a && (orow_r == lrow_a) && (ocp1 >= lcnt_a);
    row_end = is_last || (ocp1 >= wrow);
  end

  assign q_push                = acc && due;

  always_comb begin
    lw_nxt     = lw_r;
    icol_nxt   = icol_r;
    irow_nxt   = irow_r;
    closed_nxt = closed_r;
    lrow_nxt   = lrow_r;
    lcnt_nxt   = lcnt_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    base_nxt   = base_r;
    if (acc) begin
      lw_nxt     = lw_a;
      icol_nxt   = icol_a;
      irow_nxt   = irow_a;
      closed_nxt = closed_a;
      lrow_nxt   = lrow_a;
      lcnt_nxt   = lcnt_a;
    end
    if (q_push) begin
      if (is_last) begin
        lw_nxt     = '0;
        icol_nxt   = '0;
        irow_nxt   = '0;
        closed_nxt = 1'b0;
        lrow_nxt   = '0;
        lcnt_nxt   = '0;
        ocol_nxt   = '0;
        orow_nxt   = '0;
        base_nxt   = base_r + lrow_a[icc_pkg::SLOT_W-1:0] + icc_pkg::SLOT_W'(1);
      end else if (row_end) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + icc_pkg::ROW_W'(1);
      end else begin
        ocol_nxt = ocol_r + icc_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r     <= '0;
      icol_r   <= '0;
      irow_r   <= '0;
      closed_r <= 1'b0;
      lrow_r   <= '0;
      lcnt_r   <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
      base_r   <= '0;
    end else begin
      lw_r     <= lw_nxt;
      icol_r   <= icol_nxt;
      irow_r   <= irow_nxt;
      closed_r <= closed_nxt;
      lrow_r   <= lrow_nxt;
      lcnt_r   <= lcnt_nxt;
      ocol_r   <= ocol_nxt;
      orow_r   <= orow_nxt;
      base_r   <= base_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/icc_queue.sv =====
// Two-entry job queue between the front end and the convolution back end.
// Depends on icc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire icc_pkg::job_t  din,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output icc_pkg::job_t       dout
);

  icc_pkg::job_t                 ent_r [icc_pkg::Q_DEPTH];
  logic [icc_pkg::Q_PTR_W-1:0]   wp_r, rp_r;
  logic [icc_pkg::Q_PTR_W:0]     cnt_r;

  assign full  = (cnt_r == (icc_pkg::Q_PTR_W+1)'(icc_pkg::Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + icc_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + icc_pkg::Q_PTR_W'(1);
      end
      cnt_r <= cnt_r + (icc_pkg::Q_PTR_W+1)'(push) - (icc_pkg::Q_PTR_W+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/icc_back.sv =====
// Back end: line store, column fetch, 5x5 window, multiply and adder tree,
// rounding, saturation and the output register. Depends on icc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icc_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire icc_pkg::cfg_t             cfg,
  input  wire icc_pkg::line_wr_t         line_wr,
  input  wire logic                      q_valid,
  input  wire icc_pkg::job_t             q_job,
  output logic                           q_pop,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [icc_pkg::CH_W-1:0]       out_red_out,
  output logic [icc_pkg::CH_W-1:0]       out_green_out,
  output logic [icc_pkg::CH_W-1:0]       out_blue_out,
  output logic [icc_pkg::CH_W-1:0]       out_alpha_out,
  output logic                           out_row_end_out,
  output logic                           out_frame_end_out,
  output logic                           out_mask_error
);

  localparam int M  = icc_pkg::MAX_MASK;
  localparam int NC = icc_pkg::NUM_CH;

  logic en, issue, xz, last_step;
  logic [icc_pkg::STEP_W-1:0] step_r;
  logic [icc_pkg::WID_W-1:0]  colraw;
  logic [icc_pkg::COL_W-1:0]  raddr [M];
  logic [icc_pkg::COL_W-1:0]  mem_addr [icc_pkg::NSLOT];
  logic [icc_pkg::NSLOT-1:0][icc_pkg::PIX_W-1:0] rd_data;

  logic                               t1_valid_r, t1_load_r, t1_emit_r;
  logic [M-1:0][icc_pkg::SLOT_W-1:0]  t1_slot_r;
  icc_pkg::flags_t                    t1_flags_r, t2_flags_r, t3_flags_r, t4_flags_r, t5_flags_r;
  logic                               t2_valid_r, t3_valid_r, t4_valid_r, t5_valid_r;
  logic [icc_pkg::CH_W-1:0]           t3_alpha_r, t4_alpha_r, t5_alpha_r;
  logic [icc_pkg::PIX_W-1:0]          win_r [M][M];

  logic signed [icc_pkg::COEF_BITS-1:0] coef_eff [M][M];
  logic signed [icc_pkg::PROD_W-1:0]    prod_r [NC][M][M];
  logic signed [icc_pkg::RSUM_W-1:0]    rsum_nxt [NC][M];
  logic signed [icc_pkg::RSUM_W-1:0]    rsum_r [NC][M];
  logic signed [icc_pkg::TSUM_W-1:0]    tot_nxt [NC];
  logic signed [icc_pkg::TSUM_W-1:0]    tot_r [NC];
  logic signed [icc_pkg::TSUM_W:0]      rnd, v;
  logic [icc_pkg::CH_W-1:0]             fin [NC];

  logic                       out_valid_r;
  logic [icc_pkg::CH_W-1:0]   red_r, green_r, blue_r, alpha_r;
  logic                       row_end_r, frame_end_r, err_r;

  assign en = !out_valid_r || out_ready;

  // fetch: a row start reads columns 0..HALF, later outputs read column x+HALF
  assign xz        = (q_job.col == '0);
  assign last_step = !xz || (step_r == icc_pkg::STEP_W'(icc_pkg::HALF));
  assign issue     = q_valid && en;
  assign q_pop     = issue && last_step;
  assign colraw    = xz ? icc_pkg::WID_W'(step_r)
                        : ({1'b0, q_job.col} + icc_pkg::WID_W'(icc_pkg::HALF));

  always_comb begin
    for (int r = 0; r < M; r++) begin
      raddr[r] = (colraw > {1'b0, q_job.lim[r]}) ? q_job.lim[r]
                                                 : colraw[icc_pkg::COL_W-1:0];
    end
    for (int s = 0; s < icc_pkg::NSLOT; s++) begin
      mem_addr[s] = raddr[0];
      for (int r = M - 1; r >= 0; r--) begin
        if (q_job.slot[r] == icc_pkg::SLOT_W'(s)) begin
          mem_addr[s] = raddr[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (issue) begin
      if (last_step) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + icc_pkg::STEP_W'(1);
      end
    end
  end

  for (genvar s = 0; s < icc_pkg::NSLOT; s++) begin : g_slot
    logic [icc_pkg::PIX_W-1:0] mem [icc_pkg::MAX_WIDTH];
    logic [icc_pkg::PIX_W-1:0] rd_r;
    always_ff @(posedge clk) begin
      if (line_wr.en && (line_wr.slot == icc_pkg::SLOT_W'(s))) begin
        mem[line_wr.addr] <= line_wr.data;
      end
      if (en) begin
        rd_r <= mem[mem_addr[s]];
      end
    end
    assign rd_data[s] = rd_r;
  end

  always_comb begin
    for (int r = 0; r < M; r++) begin
      for (int c = 0; c < M; c++) begin
        if ((((r > icc_pkg::HALF) ? r - icc_pkg::HALF : icc_pkg::HALF - r) <=
             int'(cfg.mask_rows >> 1)) &&
            (((c > icc_pkg::HALF) ? c - icc_pkg::HALF : icc_pkg::HALF - c) <=
             int'(cfg.mask_cols >> 1))) begin
          coef_eff[r][c] = $signed(cfg.coef[r][icc_pkg::COEF_BITS*c +: icc_pkg::COEF_BITS]);
        end else begin
          coef_eff[r][c] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NC; ch++) begin
      tot_nxt[ch] = '0;
      for (int r = 0; r < M; r++) begin
        rsum_nxt[ch][r] = '0;
        for (int c = 0; c < M; c++) begin
          rsum_nxt[ch][r] = rsum_nxt[ch][r] + icc_pkg::RSUM_W'(prod_r[ch][r][c]);
        end
        tot_nxt[ch] = tot_nxt[ch] + icc_pkg::TSUM_W'(rsum_r[ch][r]);
      end
    end
  end

  // round half up, shift, saturate to 0..255
  always_comb begin
    rnd = '0;
    v   = '0;
    if (cfg.norm_shift != '0) begin
      rnd = (icc_pkg::TSUM_W+1)'(1) << (cfg.norm_shift - icc_pkg::SHIFT_W'(1));
    end
    for (int ch = 0; ch < NC; ch++) begin
      v = (icc_pkg::TSUM_W+1)'(tot_r[ch]) + rnd;
      v = v >>> cfg.norm_shift;
      if (v < 0) begin
        fin[ch] = '0;
      end else if (v > 255) begin
        fin[ch] = '1;
      end else begin
        fin[ch] = v[icc_pkg::CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_valid_r  <= 1'b0;
      t2_valid_r  <= 1'b0;
      t3_valid_r  <= 1'b0;
      t4_valid_r  <= 1'b0;
      t5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      t1_valid_r  <= issue;
      t2_valid_r  <= t1_valid_r && t1_emit_r;
      t3_valid_r  <= t2_valid_r;
      t4_valid_r  <= t3_valid_r;
      t5_valid_r  <= t4_valid_r;
      out_valid_r <= t5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_load_r  <= xz && (step_r == '0);
      t1_emit_r  <= last_step;
      t1_slot_r  <= q_job.slot;
      t1_flags_r <= q_job.flags;
      t2_flags_r <= t1_flags_r;
      t3_flags_r <= t2_flags_r;
      t4_flags_r <= t3_flags_r;
      t5_flags_r <= t4_flags_r;
      t3_alpha_r <= win_r[icc_pkg::HALF][icc_pkg::HALF][icc_pkg::PIX_W-1 -: icc_pkg::CH_W];
      t4_alpha_r <= t3_alpha_r;
      t5_alpha_r <= t4_alpha_r;
      if (t1_valid_r) begin
        for (int r = 0; r < M; r++) begin
          for (int c = 0; c < M; c++) begin
            if (t1_load_r || (c == M - 1)) begin
              win_r[r][c] <= rd_data[t1_slot_r[r]];
            end else begin
              win_r[r][c] <= win_r[r][c+1];
            end
          end
        end
      end
      for (int ch = 0; ch < NC; ch++) begin
        for (int r = 0; r < M; r++) begin
          for (int c = 0; c < M; c++) begin
            prod_r[ch][r][c] <= coef_eff[r][c] *
                                $signed({1'b0, win_r[r][c][icc_pkg::CH_W*ch +: icc_pkg::CH_W]});
          end
          rsum_r[ch][r] <= rsum_nxt[ch][r];
        end
        tot_r[ch] <= tot_nxt[ch];
      end
      if (t5_valid_r) begin
        red_r       <= t5_flags_r.err ? '0 : fin[0];
        green_r     <= t5_flags_r.err ? '0 : fin[1];
        blue_r      <= t5_flags_r.err ? '0 : fin[2];
        alpha_r     <= t5_flags_r.err ? '0 : t5_alpha_r;
        row_end_r   <= t5_flags_r.row_end;
        frame_end_r <= t5_flags_r.frame_end;
        err_r       <= t5_flags_r.err;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red_out       = red_r;
  assign out_green_out     = green_r;
  assign out_blue_out      = blue_r;
  assign out_alpha_out     = alpha_r;
  assign out_row_end_out   = row_end_r;
  assign out_frame_end_out = frame_end_r;
  assign out_mask_error    = err_r;

endmodule

`default_nettype wire

// ===== rtl/image_convolution_clamped_edges.sv =====
// Streaming RGBA8 convolution, up to 5x5 odd mask, clamp-to-edge borders.
// Top level: configuration registers, front end, job queue and back end.
// Depends on icc_pkg, icc_front, icc_queue, icc_back.
//
// Usage: pixels enter in raster order on the in_ channel (valid/ready), with row-end and
// frame-end marks; after frame end, drain requests (in_command = 1) bring out the
// remaining pixels, at most one result per request. Results leave on the out_ channel.
// The first row's row-end mark sets the width; the frame-end mark sets the height.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while the block is idle.
// A due request pushes a job into the queue; the job then passes the fetch, window,
// product, row-sum, total and output registers. The first job of a row fetches its left
// border columns first. Throughput: one request per cycle while the job queue has room;
// as each row start also fetches its border columns, a continuous stream stalls once
// the two-entry job queue has filled.
// The line store is eight rows of block RAM and needs no clearing pass.
// Reset (rst_n low, synchronous) empties the pipeline, clears the frame counters and loads
// the identity 3x3 mask. When out_ready is low the back end holds, the queue fills and
// in_ready drops after at most two further jobs.
`timescale 1ns / 1ps
`default_nettype none

module image_convolution_clamped_edges (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [icc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [icc_pkg::COEF_ROW_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_command,
  input  wire logic [icc_pkg::CH_W-1:0]          in_red_in,
  input  wire logic [icc_pkg::CH_W-1:0]          in_green_in,
  input  wire logic [icc_pkg::CH_W-1:0]          in_blue_in,
  input  wire logic [icc_pkg::CH_W-1:0]          in_alpha_in,
  input  wire logic                              in_row_end_in,
  input  wire logic                              in_frame_end_in,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [icc_pkg::CH_W-1:0]               out_red_out,
  output logic [icc_pkg::CH_W-1:0]               out_green_out,
  output logic [icc_pkg::CH_W-1:0]               out_blue_out,
  output logic [icc_pkg::CH_W-1:0]               out_alpha_out,
  output logic                                   out_row_end_out,
  output logic                                   out_frame_end_out,
  output logic                                   out_mask_error
);

  logic [icc_pkg::COEF_ROW_W-1:0] coef_r [icc_pkg::MAX_MASK];
  logic [icc_pkg::SHIFT_W-1:0]    shift_r;
  logic [icc_pkg::MSIZE_W-1:0]    cols_r, rows_r;
  icc_pkg::cfg_t                  cfg;

  logic              q_full, q_push, q_pop, q_valid;
  icc_pkg::job_t     q_in, q_out;
  icc_pkg::line_wr_t line_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < icc_pkg::MAX_MASK; r++) begin
        coef_r[r] <= (r == icc_pkg::HALF) ?
                     (icc_pkg::COEF_ROW_W'(1) << (icc_pkg::COEF_BITS * icc_pkg::HALF)) : '0;
      end
      shift_r <= '0;
      cols_r  <= icc_pkg::MSIZE_W'(3);
      rows_r  <= icc_pkg::MSIZE_W'(3);
    end else if (cfg_wr_en) begin
      case (icc_pkg::cfg_reg_t'(cfg_index))
        icc_pkg::REG_COEF_ROW0:  coef_r[0] <= cfg_data;
        icc_pkg::REG_COEF_ROW1:  coef_r[1] <= cfg_data;
        icc_pkg::REG_COEF_ROW2:  coef_r[2] <= cfg_data;
        icc_pkg::REG_COEF_ROW3:  coef_r[3] <= cfg_data;
        icc_pkg::REG_COEF_ROW4:  coef_r[4] <= cfg_data;
        icc_pkg::REG_NORM_SHIFT: shift_r   <= cfg_data[icc_pkg::SHIFT_W-1:0];
        icc_pkg::REG_MASK_COLS:  cols_r    <= cfg_data[icc_pkg::MSIZE_W-1:0];
        icc_pkg::REG_MASK_ROWS:  rows_r    <= cfg_data[icc_pkg::MSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < icc_pkg::MAX_MASK; r++) begin
      cfg.coef[r] = coef_r[r];
    end
    cfg.norm_shift = shift_r;
    cfg.mask_cols  = cols_r;
    cfg.mask_rows  = rows_r;
  end

  icc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .in_alpha_in     (in_alpha_in),
    .in_row_end_in   (in_row_end_in),
    .in_frame_end_in (in_frame_end_in),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_in),
    .line_wr         (line_wr)
  );

  icc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_out)
  );

  icc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .line_wr           (line_wr),
    .q_valid           (q_valid),
    .q_job             (q_out),
    .q_pop             (q_pop),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .out_alpha_out     (out_alpha_out),
    .out_row_end_out   (out_row_end_out),
    .out_frame_end_out (out_frame_end_out),
    .out_mask_error    (out_mask_error)
  );

endmodule

`default_nettype wire
